[design/aging_device_table_unit_defines.svh]
// ----------------------------------------------------------------------------
// Aging device table assertion macros
// Shared assertion forms for the aging device table.
// ----------------------------------------------------------------------------
`ifndef AGING_DEVICE_TABLE_UNIT_DEFINES_SVH
`define AGING_DEVICE_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/adt_pkg.sv]
// ----------------------------------------------------------------------------
// Aging device table package
// Shared constants, result codes and the compare result type.
// ----------------------------------------------------------------------------
`default_nettype none

package adt_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_ID_BYTES    = 8;

    localparam int NODE_ID_W = 64;
    localparam int TIME_W    = 32;
    localparam int FIELD_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int OUT_W     = 16;

    localparam logic [TIME_W-1:0] TTL_RESET = 32'd3000;

    localparam logic FUNC_UPSERT = 1'b0;
    localparam logic FUNC_SWEEP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic key_eq;
        logic stale;
    } t_cmp_res;

endpackage

`default_nettype wire

[design/adt_entry_store.sv]
// ----------------------------------------------------------------------------
// Aging device table entry store
// Key and timestamp memories with a registered read port and the shared
// key and age compare unit working on the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module adt_entry_store
    import adt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_W       = 8 * DEF_ID_BYTES,
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic              i_wr_key_en,
    input  wire logic [IDX_W-1:0]  i_wr_addr,
    input  wire logic              i_rd_en,
    input  wire logic [IDX_W-1:0]  i_rd_addr,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [TIME_W-1:0] i_now,
    input  wire logic [TIME_W-1:0] i_ttl,
    output t_cmp_res               o_cmp
);

    logic [KEY_W-1:0]  mem_key   [TABLE_DEPTH];
    logic [TIME_W-1:0] mem_stamp [TABLE_DEPTH];

    logic [KEY_W-1:0]  r_rd_key;
    logic [TIME_W-1:0] r_rd_stamp;
    logic [TIME_W-1:0] w_age;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_stamp[i_wr_addr] <= i_now;
            if (i_wr_key_en) begin
                mem_key[i_wr_addr] <= i_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_key   <= mem_key[i_rd_addr];
            r_rd_stamp <= mem_stamp[i_rd_addr];
        end
    end

    // Age wraps modulo 2^32, so a stamp ahead of now reads as very old.
    assign w_age        = i_now - r_rd_stamp;
    assign o_cmp.key_eq = (r_rd_key == i_key);
    assign o_cmp.stale  = (w_age >= i_ttl);

endmodule

`default_nettype wire

[design/aging_device_table_unit.sv]
// ----------------------------------------------------------------------------
// Aging device table unit
// Learning table of node identifiers with last-seen timestamps and aging.
// ----------------------------------------------------------------------------
// An upsert transaction (tuser 0) looks up the identifier, refreshes its
// timestamp on a hit, and otherwise inserts it into the lowest free slot or
// reports the table full. A sweep transaction (tuser 1) removes every valid
// entry whose wrapped age is at least the TTL register. Every input
// transaction yields one result transaction carrying the status, the number
// removed and the live count. The entries are visited one per cycle through
// the single read port of the entry store, with a registered read ahead of the
// first compare, followed by an update state and a result state. The input is
// not ready from acceptance until the result is presented, and is ready again
// in the same cycle as the result is presented, so no new item is taken before
// the current one is through. A finished result waits in an output register
// while the next item is taken; if that register is still occupied when the
// next result is done, the block holds the result and the input until the
// register drains. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aging_device_table_unit_defines.svh"

module aging_device_table_unit
    import adt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BYTES    = DEF_ID_BYTES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [TIME_W-1:0]           i_cfg_wr_data,   // ttl
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [NODE_ID_W+TIME_W-1:0] i_s_axis_tdata,  // node_id[63:0], now[95:64]
    input  wire logic                        i_s_axis_tuser,  // func
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [OUT_W-1:0]                 o_m_axis_tdata   // status, removed, live_count
);

    localparam int KEY_W = 8 * ID_BYTES;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = CNT_W + FIELD_W;
    localparam int PAD_W = OUT_W - STATUS_W - 2 * FIELD_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]             r_state;
    logic [TIME_W-1:0]      r_ttl;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_total;
    logic [CNT_W-1:0]       r_gone;
    logic [IDX_W-1:0]       r_addr;
    logic                   r_issue_done;
    logic                   r_pend;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_hit;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [IDX_W-1:0]       r_free_idx;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;

    logic                   r_func;
    logic [KEY_W-1:0]       r_key;
    logic [TIME_W-1:0]      r_now;

    logic                   w_accept;
    logic                   w_rd_en;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    logic                   w_cur_valid;
    logic                   w_out_load;
    logic [EXT_W-1:0]       w_live_ext;
    logic [EXT_W-1:0]       w_gone_ext;
    t_cmp_res               w_cmp;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_rd_en         = (r_state == ST_SCAN) && !r_issue_done;
    assign w_wr_en         = (r_state == ST_WRITE) && (r_func == FUNC_UPSERT)
                             && (r_hit || r_free_found);
    assign w_wr_addr       = r_hit ? r_hit_idx : r_free_idx;
    assign w_cur_valid     = r_valid[r_cmp_idx];
    assign w_out_load      = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);
    assign w_live_ext      = EXT_W'(r_total);
    assign w_gone_ext      = EXT_W'(r_gone);

    adt_entry_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_W       (KEY_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_key_en (!r_hit),
        .i_wr_addr   (w_wr_addr),
        .i_rd_en     (w_rd_en),
        .i_rd_addr   (r_addr),
        .i_key       (r_key),
        .i_now       (r_now),
        .i_ttl       (r_ttl),
        .o_cmp       (w_cmp)
    );

    // Item payload is captured once per transaction and held during the scan.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_s_axis_tuser;
            r_key  <= i_s_axis_tdata[KEY_W-1:0];
            r_now  <= i_s_axis_tdata[NODE_ID_W +: TIME_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ttl        <= TTL_RESET;
            r_valid      <= '0;
            r_total      <= '0;
            r_gone       <= '0;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
            r_cmp_idx    <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_hit_idx    <= '0;
            r_free_idx   <= '0;
            r_status     <= STATUS_OK;
            r_out_valid  <= 1'b0;
            r_out_data   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ttl <= i_cfg_wr_data;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state      <= ST_SCAN;
                        r_addr       <= '0;
                        r_issue_done <= 1'b0;
                        r_pend       <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_gone       <= '0;
                    end
                end
                ST_SCAN: begin
                    // Read issue for one entry overlaps the compare of the previous one.
                    if (!r_issue_done) begin
                        r_cmp_idx <= r_addr;
                        r_pend    <= 1'b1;
                        if (r_addr == IDX_W'(TABLE_DEPTH - 1)) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + IDX_W'(1);
                        end
                    end else begin
                        r_pend <= 1'b0;
                    end

                    if (r_pend) begin
                        if (r_func == FUNC_UPSERT) begin
                            if (w_cur_valid && w_cmp.key_eq && !r_hit) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_cmp_idx;
                            end
                            if (!w_cur_valid && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_cmp_idx;
                            end
                        end else if (w_cur_valid && w_cmp.stale) begin
                            r_valid[r_cmp_idx] <= 1'b0;
                            r_gone             <= r_gone + CNT_W'(1);
                        end
                        if (r_cmp_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                            r_state <= ST_WRITE;
                        end
                    end
                end
                ST_WRITE: begin
                    if (r_func == FUNC_SWEEP) begin
                        r_total  <= r_total - r_gone;
                        r_status <= STATUS_OK;
                    end else if (r_hit) begin
                        r_status <= STATUS_OK;
                    end else if (r_free_found) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_total             <= r_total + CNT_W'(1);
                        r_status            <= STATUS_INSERTED;
                    end else begin
                        r_status <= STATUS_FULL;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_out_data  <= {PAD_W'(0), w_live_ext[FIELD_W-1:0],
                                        w_gone_ext[FIELD_W-1:0], r_status};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Valid bits are cleared during a sweep scan before the count catches up.
    `ADT_ASSERT_SAME(a_total_matches_valid, i_clk, i_rst_n, r_state == ST_IDLE || r_state == ST_DONE, CNT_W'($countones(r_valid)) == r_total, "live count disagrees with valid bits")
    `ADT_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, w_accept, r_state == ST_SCAN && !r_pend, "accepted item did not start a scan")
    `ADT_ASSERT_SAME(a_full_only_when_full, i_clk, i_rst_n, w_out_load && r_status == STATUS_FULL, r_total == CNT_W'(TABLE_DEPTH), "table full reported with a free slot")
    `ADT_ASSERT_NEXT(a_result_after_done, i_clk, i_rst_n, w_out_load, o_m_axis_tvalid && r_state == ST_IDLE, "result not presented after completion")

endmodule

`default_nettype wire
